FILE: rtl/voxel_face_culling_mesher_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel face culling mesher
// Concurrent assertion helpers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_MESHER_ASSERT_SVH
`define VOXEL_FACE_CULLING_MESHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define VFCM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("vfcm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define VFCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("vfcm assertion failed");

`else

`define VFCM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define VFCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// Voxel face culling mesher package
// Chunk geometry, field widths and the shared types of the mesher.
// ----------------------------------------------------------------------------
`default_nettype none

package vfcm_pkg;

	localparam int CHUNK_SIDE = 16;
	localparam int COORD_W    = $clog2(CHUNK_SIDE);
	localparam int ADDR_W     = 3 * COORD_W;
	localparam int CELLS      = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
	localparam int TYPE_W     = 8;
	localparam int COUNT_W    = 15;
	localparam int BASE_W     = COUNT_W + 2;
	localparam int NUM_SIDES  = 6;
	localparam int SIDE_W     = 3;

	localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(CHUNK_SIDE - 1);
	localparam logic [TYPE_W-1:0]  AIR        = '0;
	localparam logic [TYPE_W-1:0]  OFFSET_TYPE_RESET = TYPE_W'(2);

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_MESH  = 1'b1
	} kind_t;

	typedef enum logic [SIDE_W-1:0] {
		SIDE_PX = 3'd0,
		SIDE_NX = 3'd1,
		SIDE_PY = 3'd2,
		SIDE_NY = 3'd3,
		SIDE_PZ = 3'd4,
		SIDE_NZ = 3'd5
	} side_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} coord_t;

	typedef struct packed {
		logic              at_edge;
		logic [ADDR_W-1:0] addr;
	} nbr_t;

endpackage

`default_nettype wire

FILE: rtl/vfcm_if.sv
// ----------------------------------------------------------------------------
// Voxel face culling mesher channels
// Valid/ready channels for items, face records and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfcm_item_if;
	logic                            valid;
	logic                            ready;
	vfcm_pkg::kind_t                 kind;
	logic [vfcm_pkg::COORD_W-1:0]    cell_x;
	logic [vfcm_pkg::COORD_W-1:0]    cell_y;
	logic [vfcm_pkg::COORD_W-1:0]    cell_z;
	logic [vfcm_pkg::TYPE_W-1:0]     block_value;
	logic                            first_cell;

	modport source (output valid, kind, cell_x, cell_y, cell_z, block_value, first_cell,
		input ready);
	modport sink (input valid, kind, cell_x, cell_y, cell_z, block_value, first_cell,
		output ready);
endinterface

interface vfcm_face_if;
	logic                            valid;
	logic                            ready;
	logic [vfcm_pkg::COORD_W-1:0]    face_x;
	logic [vfcm_pkg::COORD_W-1:0]    face_y;
	logic [vfcm_pkg::COORD_W-1:0]    face_z;
	vfcm_pkg::side_t                 side;
	logic                            atlas_column;
	logic [vfcm_pkg::BASE_W-1:0]     base_vertex;
	logic                            last_face;

	modport source (output valid, face_x, face_y, face_z, side, atlas_column, base_vertex,
		last_face, input ready);
	modport sink (input valid, face_x, face_y, face_z, side, atlas_column, base_vertex,
		last_face, output ready);
endinterface

interface vfcm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [vfcm_pkg::TYPE_W-1:0]     data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/voxel_face_culling_mesher.sv
// ----------------------------------------------------------------------------
// Voxel face culling mesher
// Keeps a chunk of block types and emits the visible faces of meshed cells.
// ----------------------------------------------------------------------------
// After reset the block clears the block store to air, one cell per cycle,
// and accepts no item until that pass is done (the configuration port is
// open throughout). A write item then goes straight into the store. A mesh
// item first reads the named cell; an air cell ends there. A solid cell then
// reads its six neighbors through the single read port of the store, one per
// cycle, collects the last read in a drain state, and emits one face record
// per cycle after that, except while the face channel stalls. The store's
// single read port is why the neighbors are read one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_face_culling_mesher_assert.svh"

module voxel_face_culling_mesher (
	input  wire              clk,
	input  wire              arst_n,
	vfcm_item_if.sink        item,
	vfcm_face_if.source      face,
	vfcm_cfg_if.sink         cfg
);

	// ------------------------------------------------------------------
	// Configuration register. Writes are only expected while idle, so the
	// port is always ready.
	// ------------------------------------------------------------------
	logic [vfcm_pkg::TYPE_W-1:0] offset_type_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_type_q <= vfcm_pkg::OFFSET_TYPE_RESET;
		end else if (cfg.valid) begin
			offset_type_q <= cfg.data;
		end
	end

	// ------------------------------------------------------------------
	// Control state and datapath registers.
	// ------------------------------------------------------------------
	vfcm_pkg::state_t                  state_q, state_d;
	logic                              clr_busy_q;
	logic [vfcm_pkg::ADDR_W-1:0]       clr_addr_q;
	vfcm_pkg::coord_t                  cell_q;
	vfcm_pkg::side_t                   side_q;
	logic [vfcm_pkg::NUM_SIDES-1:0]    mask_q;
	logic                              atlas_q;
	logic [vfcm_pkg::COUNT_W-1:0]      count_q;
	logic [vfcm_pkg::TYPE_W-1:0]       rd_data_q;

	// Neighbor check pipeline: the read for a side is issued in one cycle and
	// its data is judged in the next.
	logic                              chk_valid_s1;
	logic                              chk_edge_s1;
	vfcm_pkg::side_t                   chk_side_s1;

	logic                              item_ready;
	logic                              item_fire;
	logic                              emit_load;
	logic                              emit_last;
	logic [vfcm_pkg::SIDE_W-1:0]       emit_idx;
	logic [vfcm_pkg::NUM_SIDES-1:0]    emit_rest;
	logic                              mask_hit;
	logic [vfcm_pkg::NUM_SIDES-1:0]    mask_d;
	vfcm_pkg::nbr_t                    nbr;
	logic                              out_valid_q;

	assign item.ready = item_ready;
	assign item_fire  = item.valid && item_ready;

	// The shared neighbor unit walks the six sides of the latched cell.
	vfcm_nbr_unit u_nbr (
		.origin (cell_q),
		.side   (side_q),
		.nbr    (nbr)
	);

	// A side is visible on the chunk boundary or when its neighbor is air.
	assign mask_hit = chk_valid_s1 && (chk_edge_s1 || rd_data_q == vfcm_pkg::AIR);
	assign mask_d   = mask_q | (mask_hit ? (vfcm_pkg::NUM_SIDES'(1) << chk_side_s1) : '0);

	// Lowest pending side goes out first, which keeps the +X..-Z order.
	always_comb begin
		emit_idx = '0;
		for (int i = vfcm_pkg::NUM_SIDES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				emit_idx = vfcm_pkg::SIDE_W'(i);
			end
		end
	end

	assign emit_rest = mask_q & ~(vfcm_pkg::NUM_SIDES'(1) << emit_idx);
	assign emit_last = (emit_rest == '0);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			vfcm_pkg::ST_IDLE: begin
				item_ready = !clr_busy_q;
				if (item_fire && item.kind == vfcm_pkg::KIND_MESH) begin
					state_d = vfcm_pkg::ST_CENTER;
				end
			end
			vfcm_pkg::ST_CENTER: begin
				if (rd_data_q == vfcm_pkg::AIR) begin
					state_d = vfcm_pkg::ST_IDLE;
				end else begin
					state_d = vfcm_pkg::ST_SCAN;
				end
			end
			vfcm_pkg::ST_SCAN: begin
				if (side_q == vfcm_pkg::SIDE_NZ) begin
					state_d = vfcm_pkg::ST_DRAIN;
				end
			end
			vfcm_pkg::ST_DRAIN: begin
				if (mask_d == '0) begin
					state_d = vfcm_pkg::ST_IDLE;
				end else begin
					state_d = vfcm_pkg::ST_EMIT;
				end
			end
			vfcm_pkg::ST_EMIT: begin
				if (!out_valid_q || face.ready) begin
					emit_load = 1'b1;
					if (emit_last) begin
						state_d = vfcm_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = vfcm_pkg::ST_IDLE;
		endcase
	end

	// Control registers that reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q   <= 1'b1;
			clr_addr_q   <= '0;
			count_q      <= '0;
			chk_valid_s1 <= 1'b0;
			mask_q       <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (item_fire && item.kind == vfcm_pkg::KIND_MESH && item.first_cell) begin
				count_q <= '0;
			end else if (emit_load) begin
				count_q <= count_q + 1'b1;
			end
			chk_valid_s1 <= (state_q == vfcm_pkg::ST_SCAN);
			if (state_q == vfcm_pkg::ST_CENTER) begin
				mask_q <= '0;
			end else if (emit_load) begin
				mask_q <= emit_rest;
			end else begin
				mask_q <= mask_d;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			cell_q <= '{x: item.cell_x, y: item.cell_y, z: item.cell_z};
		end
		if (state_q == vfcm_pkg::ST_CENTER) begin
			side_q  <= vfcm_pkg::SIDE_PX;
			atlas_q <= (rd_data_q == offset_type_q);
		end else if (state_q == vfcm_pkg::ST_SCAN && side_q != vfcm_pkg::SIDE_NZ) begin
			side_q <= vfcm_pkg::side_t'(side_q + 1'b1);
		end
		chk_edge_s1 <= nbr.at_edge;
		chk_side_s1 <= side_q;
	end

	// ------------------------------------------------------------------
	// Block store: one write port shared by the clearing pass and write
	// items, one registered read port. With 4-bit coordinates every cell
	// named by an item lies inside the chunk.
	// ------------------------------------------------------------------
	logic [vfcm_pkg::TYPE_W-1:0] store_mem [vfcm_pkg::CELLS];
	logic                        wr_en;
	logic [vfcm_pkg::ADDR_W-1:0] wr_addr;
	logic [vfcm_pkg::TYPE_W-1:0] wr_data;
	logic [vfcm_pkg::ADDR_W-1:0] rd_addr;

	assign wr_en   = clr_busy_q || (item_fire && item.kind == vfcm_pkg::KIND_WRITE);
	assign wr_addr = clr_busy_q ? clr_addr_q : {item.cell_x, item.cell_y, item.cell_z};
	assign wr_data = clr_busy_q ? vfcm_pkg::AIR : item.block_value;
	assign rd_addr = (state_q == vfcm_pkg::ST_SCAN) ? nbr.addr
		: {item.cell_x, item.cell_y, item.cell_z};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= store_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Face output register. A record waits here while the sequencer moves on
	// to the next side.
	// ------------------------------------------------------------------
	logic [vfcm_pkg::COORD_W-1:0] face_x_q;
	logic [vfcm_pkg::COORD_W-1:0] face_y_q;
	logic [vfcm_pkg::COORD_W-1:0] face_z_q;
	vfcm_pkg::side_t              face_side_q;
	logic                         face_atlas_q;
	logic [vfcm_pkg::BASE_W-1:0]  face_base_q;
	logic                         face_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (face.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			face_x_q     <= cell_q.x;
			face_y_q     <= cell_q.y;
			face_z_q     <= cell_q.z;
			face_side_q  <= vfcm_pkg::side_t'(emit_idx);
			face_atlas_q <= atlas_q;
			face_base_q  <= {count_q, 2'b00};
			face_last_q  <= emit_last;
		end
	end

	assign face.valid        = out_valid_q;
	assign face.face_x       = face_x_q;
	assign face.face_y       = face_y_q;
	assign face.face_z       = face_z_q;
	assign face.side         = face_side_q;
	assign face.atlas_column = face_atlas_q;
	assign face.base_vertex  = face_base_q;
	assign face.last_face    = face_last_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`VFCM_ASSERT_SAME(a_ready_only_idle, clk, arst_n, item.ready, (state_q == vfcm_pkg::ST_IDLE) && !clr_busy_q)
	`VFCM_ASSERT_SAME(a_emit_has_faces, clk, arst_n, state_q == vfcm_pkg::ST_EMIT, mask_q != '0)
	`VFCM_ASSERT_NEXT(a_count_steps, clk, arst_n, emit_load, count_q == $past(count_q) + 1'b1)
	`VFCM_ASSERT_NEXT(a_last_ends_cell, clk, arst_n, emit_load && emit_last, state_q == vfcm_pkg::ST_IDLE)
	`VFCM_ASSERT_SAME(a_check_in_scan, clk, arst_n, chk_valid_s1, (state_q == vfcm_pkg::ST_SCAN) || (state_q == vfcm_pkg::ST_DRAIN))

endmodule

`default_nettype wire

FILE: rtl/vfcm_nbr_unit.sv
// ----------------------------------------------------------------------------
// Neighbor address unit
// Steps one coordinate toward a side and flags sides on the chunk boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_nbr_unit (
	input  vfcm_pkg::coord_t origin,
	input  vfcm_pkg::side_t  side,
	output vfcm_pkg::nbr_t   nbr
);

	logic [vfcm_pkg::COORD_W-1:0] c;
	logic [vfcm_pkg::COORD_W-1:0] c_step;
	logic                         plus;
	vfcm_pkg::coord_t             n;

	// Pick the axis coordinate that this side moves along.
	always_comb begin
		plus = 1'b1;
		c    = origin.x;
		unique case (side)
			vfcm_pkg::SIDE_PX: begin plus = 1'b1; c = origin.x; end
			vfcm_pkg::SIDE_NX: begin plus = 1'b0; c = origin.x; end
			vfcm_pkg::SIDE_PY: begin plus = 1'b1; c = origin.y; end
			vfcm_pkg::SIDE_NY: begin plus = 1'b0; c = origin.y; end
			vfcm_pkg::SIDE_PZ: begin plus = 1'b1; c = origin.z; end
			vfcm_pkg::SIDE_NZ: begin plus = 1'b0; c = origin.z; end
			default: begin plus = 1'b1; c = origin.x; end
		endcase
	end

	// One shared incrementer/decrementer; its result is unused on the boundary.
	assign c_step = plus ? c + 1'b1 : c - 1'b1;

	always_comb begin
		n = origin;
		unique case (side)
			vfcm_pkg::SIDE_PX, vfcm_pkg::SIDE_NX: n.x = c_step;
			vfcm_pkg::SIDE_PY, vfcm_pkg::SIDE_NY: n.y = c_step;
			vfcm_pkg::SIDE_PZ, vfcm_pkg::SIDE_NZ: n.z = c_step;
			default: n = origin;
		endcase
	end

	assign nbr.at_edge = plus ? (c == vfcm_pkg::COORD_LAST) : (c == '0);
	assign nbr.addr    = {n.x, n.y, n.z};

endmodule

`default_nettype wire
